[rtl/core/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg: shared types and constants for the sorted key/value table
// Sizes, command and status codes, cell operations and controller states.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_PUT  = 3'd0,
        CMD_GET  = 3'd1,
        CMD_READ = 3'd2,
        CMD_DEL  = 3'd3,
        CMD_LIST = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CMP,
        OP_INS,
        OP_DEL,
        OP_SET
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_LIST
    } t_state;

endpackage

[rtl/core/skvt_cell.sv]
// ----------------------------------------------------------------------------
// skvt_cell: one slot of the sorted table
// Holds one pair, compares it with the command key, and shifts its pair
// to or from a neighbor slot on insert and remove.
// ----------------------------------------------------------------------------
module skvt_cell
    import skvt_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic                  i_live,
    input  logic                  i_lower_lt,
    input  logic [KEY_BITS-1:0]   i_lower_key,
    input  logic [VALUE_BITS-1:0] i_lower_value,
    input  logic [KEY_BITS-1:0]   i_upper_key,
    input  logic [VALUE_BITS-1:0] i_upper_value,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_lt,
    output logic                  o_eq
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_lt;
    logic                  r_eq;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_CMP: begin
                r_lt <= i_live && (r_key < i_ctl.key);
                r_eq <= i_live && (r_key == i_ctl.key);
            end
            OP_INS: begin
                // slots at and above the insert point move up by one
                if (!r_lt) begin
                    if (i_lower_lt) begin
                        r_key   <= i_ctl.key;
                        r_value <= i_ctl.value;
                    end else begin
                        r_key   <= i_lower_key;
                        r_value <= i_lower_value;
                    end
                end
            end
            OP_DEL: begin
                // slots at and above the removed key move down by one
                if (!r_lt) begin
                    r_key   <= i_upper_key;
                    r_value <= i_upper_value;
                end
            end
            OP_SET: begin
                if (r_eq) begin
                    r_value <= i_ctl.value;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

[rtl/core/sorted_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table_top: sorted key/value table on a chain of slots
// Put, get-or-create, read, remove and list over pairs kept in ascending
// unsigned key order.
// ----------------------------------------------------------------------------
//  channel   valid     stall     payload
//  command   i_valid   o_stall   i_cmd, i_key, i_value
//  result    o_valid   i_stall   o_value_out, o_key_out, o_found, o_status,
//                                o_entry_count, o_last
//
//  A command steps through capture, parallel compare in every slot, then
//  shift or update and load the result register. List uses that last step
//  to start the walk, then gives one word for each stored key.
//  Reset clears the controller and the pair count; slot contents are
//  don't-care until written.
//  A stalled result holds the next word back; the command side stays stalled
//  until the controller is back in idle.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top
    import skvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_BITS-1:0] o_value_out,
    output logic [KEY_BITS-1:0]   o_key_out,
    output logic                  o_found,
    output logic [1:0]            o_status,
    output logic [CNT_W-1:0]      o_entry_count,
    output logic                  o_last
);

    t_state                r_state, n_state;
    logic [2:0]            r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_idx, n_idx;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_value_out, n_value_out;
    logic [KEY_BITS-1:0]   r_key_out, n_key_out;
    logic                  r_found, n_found;
    t_status               r_status, n_status;
    logic [CNT_W-1:0]      r_entry_count;
    logic                  r_last, n_last;

    t_cell_ctl             cell_ctl;
    logic                  in_acc;
    logic                  out_free;
    logic                  out_load;
    logic                  hit;
    logic                  full;
    logic [VALUE_BITS-1:0] hit_value;

    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   cell_lt;
    logic [CAPACITY-1:0]   cell_eq;

    // slot chain: each slot sees its lower and upper neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                  lower_lt;
        logic [KEY_BITS-1:0]   lower_key;
        logic [VALUE_BITS-1:0] lower_value;
        logic [KEY_BITS-1:0]   upper_key;
        logic [VALUE_BITS-1:0] upper_value;

        if (g == 0) begin : g_bottom
            assign lower_lt    = 1'b1;
            assign lower_key   = cell_key[g];
            assign lower_value = cell_value[g];
        end else begin : g_mid_lo
            assign lower_lt    = cell_lt[g-1];
            assign lower_key   = cell_key[g-1];
            assign lower_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_top
            assign upper_key   = cell_key[g];
            assign upper_value = cell_value[g];
        end else begin : g_mid_hi
            assign upper_key   = cell_key[g+1];
            assign upper_value = cell_value[g+1];
        end

        skvt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_live        (CNT_W'(g) < r_count),
            .i_lower_lt    (lower_lt),
            .i_lower_key   (lower_key),
            .i_lower_value (lower_value),
            .i_upper_key   (upper_key),
            .i_upper_value (upper_value),
            .o_key         (cell_key[g]),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_eq          (cell_eq[g])
        );
    end

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign hit      = |cell_eq;
    assign full     = (r_count == CNT_W'(CAPACITY));

    // at most one slot matches, so OR the masked values
    always_comb begin
        hit_value = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            if (cell_eq[j]) begin
                hit_value = hit_value | cell_value[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_cmd;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_idx          = r_idx;
        cell_ctl.op    = OP_HOLD;
        cell_ctl.key   = r_key;
        cell_ctl.value = r_value;
        out_load       = 1'b0;
        n_value_out    = '0;
        n_key_out      = '0;
        n_found        = 1'b0;
        n_status       = ST_OK;
        n_last         = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                cell_ctl.op = OP_CMP;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    case (r_cmd)
                        CMD_PUT: begin
                            if (hit) begin
                                cell_ctl.op = OP_SET;
                                n_found     = 1'b1;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                cell_ctl.op = OP_INS;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        CMD_GET: begin
                            if (hit) begin
                                n_value_out = hit_value;
                                n_found     = 1'b1;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                cell_ctl.op    = OP_INS;
                                cell_ctl.value = '0;
                                n_count        = r_count + CNT_W'(1);
                            end
                        end
                        CMD_READ: begin
                            if (hit) begin
                                n_value_out = hit_value;
                                n_found     = 1'b1;
                            end else begin
                                n_status = ST_MISS;
                            end
                        end
                        CMD_DEL: begin
                            if (hit) begin
                                cell_ctl.op = OP_DEL;
                                n_found     = 1'b1;
                                n_count     = r_count - CNT_W'(1);
                            end
                        end
                        CMD_LIST: begin
                            // empty table gives a single word; otherwise walk the slots
                            if (r_count != '0) begin
                                out_load = 1'b0;
                                n_idx    = '0;
                                n_state  = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    n_key_out = cell_key[r_idx];
                    n_found   = 1'b1;
                    n_last    = (CNT_W'(r_idx) + CNT_W'(1) == r_count);
                    if (n_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_value_out   <= n_value_out;
            r_key_out     <= n_key_out;
            r_found       <= n_found;
            r_status      <= n_status;
            r_entry_count <= n_count;
            r_last        <= n_last;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_value_out   = r_value_out;
    assign o_key_out     = r_key_out;
    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_last        = r_last;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the sorted key/value table
// Runs directed and random command streams through the table. A shadow copy
// of the sorted pairs predicts every result word, and each word that leaves
// the block is checked field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb
    import skvt_pkg::*;
();

    localparam int          IDLE_PCT        = 18;
    localparam int          HOLD_CYCLES     = 120;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          POOL_SIZE       = 24;
    localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value_out;
        logic [KEY_BITS-1:0]   key_out;
        logic                  found;
        t_status               status;
        logic [CNT_W-1:0]      count;
        logic                  last;
    } t_result_word;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [2:0]            i_cmd   = '0;
    logic [KEY_BITS-1:0]   i_key   = '0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [VALUE_BITS-1:0] o_value_out;
    logic [KEY_BITS-1:0]   o_key_out;
    logic                  o_found;
    logic [1:0]            o_status;
    logic [CNT_W-1:0]      o_entry_count;
    logic                  o_last;

    // shadow of the table contents
    logic [KEY_BITS-1:0]   shadow_keys [CAPACITY];
    logic [VALUE_BITS-1:0] shadow_vals [CAPACITY];
    int                    shadow_count = 0;

    t_result_word          expected_words [$];
    logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int fail_count = 0;
    int cmds_sent = 0;
    int words_checked = 0;
    int full_refusals = 0;
    int list_cmds = 0;

    sorted_key_value_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value_out   (o_value_out),
        .o_key_out     (o_key_out),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one accepted command to the shadow table and queue its words.
    function automatic void table_update(input logic [2:0] cmd,
                                         input logic [KEY_BITS-1:0] key,
                                         input logic [VALUE_BITS-1:0] val);
        int           slot;
        int           i;
        bit           hit;
        t_result_word w;
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < key)
            slot++;
        hit = (slot < shadow_count) && (shadow_keys[slot] == key);
        w = '0;
        w.last = 1'b1;
        case (cmd)
            CMD_PUT, CMD_GET: begin
                if (hit) begin
                    w.found = 1'b1;
                    if (cmd == CMD_PUT)
                        shadow_vals[slot] = val;
                    else
                        w.value_out = shadow_vals[slot];
                end else if (shadow_count >= CAPACITY) begin
                    w.status = ST_FULL;
                    full_refusals++;
                end else begin
                    for (i = shadow_count; i > slot; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_keys[slot] = key;
                    shadow_vals[slot] = (cmd == CMD_PUT) ? val : '0;
                    shadow_count++;
                end
            end
            CMD_READ: begin
                if (hit) begin
                    w.found     = 1'b1;
                    w.value_out = shadow_vals[slot];
                end else begin
                    w.status = ST_MISS;
                end
            end
            CMD_DEL: begin
                if (hit) begin
                    w.found = 1'b1;
                    for (i = slot; i + 1 < shadow_count; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_vals[i] = shadow_vals[i+1];
                    end
                    shadow_count--;
                end
            end
            CMD_LIST: begin
                list_cmds++;
                if (shadow_count > 0) begin
                    for (i = 0; i < shadow_count; i++) begin
                        w.key_out = shadow_keys[i];
                        w.found   = 1'b1;
                        w.count   = CNT_W'(shadow_count);
                        w.last    = (i + 1 == shadow_count);
                        expected_words.push_back(w);
                    end
                    return;
                end
            end
            default: ;
        endcase
        w.count = CNT_W'(shadow_count);
        expected_words.push_back(w);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [KEY_BITS-1:0] fresh_key();
        logic [KEY_BITS-1:0] k;
        bit                  taken;
        do begin
            k = $urandom;
            taken = 1'b0;
            for (int i = 0; i < shadow_count; i++)
                if (shadow_keys[i] == k)
                    taken = 1'b1;
        end while (taken);
        return k;
    endfunction

    // result side: random stalls, plus a long hold when a test asks for one
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (expected_words.size() == 0) begin
                $error("result word with no command waiting for it");
                fail_count++;
            end else begin
                t_result_word want;
                want = expected_words.pop_front();
                check_field("value_out", want.value_out, o_value_out);
                check_field("key_out", want.key_out, o_key_out);
                check_field("found", 32'(want.found), 32'(o_found));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("entry_count", 32'(want.count), 32'(o_entry_count));
                check_field("last", 32'(want.last), 32'(o_last));
                words_checked++;
            end
        end
    end

    // Offer one command word, possibly after a random gap; return once taken.
    task automatic send_cmd(input logic [2:0] cmd, input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_BITS-1:0] val);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_key   <= key;
        i_value <= val;
        do @(posedge i_clk); while (o_stall);
        table_update(cmd, key, val);
        cmds_sent++;
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_cmds(input int count, input int grow_pct);
        int                  r;
        logic [2:0]          cmd;
        logic [KEY_BITS-1:0] key;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < grow_pct)
                cmd = ($urandom_range(0, 2) == 0) ? CMD_GET : CMD_PUT;
            else if (r < 90)
                cmd = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_DEL;
            else if (r < 97)
                cmd = CMD_LIST;
            else
                cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            // mostly reuse a small key set so hits, overwrites and removals happen
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE-1)]
                                               : $urandom;
            send_cmd(cmd, key, $urandom);
        end
    endtask

    task automatic test_empty_table();
        send_cmd(CMD_LIST, '0, '0);
        send_cmd(CMD_READ, '0, '0);
        send_cmd(CMD_DEL, '1, '0);
        wait_results_done();
    endtask

    task automatic test_basic_ops();
        send_cmd(CMD_PUT, '0, '1);
        send_cmd(CMD_PUT, '1, '0);
        send_cmd(CMD_PUT, '0, 32'h1234_5678);
        send_cmd(CMD_GET, '1, '0);
        send_cmd(CMD_GET, 32'h8000_0000, 32'hFFFF_0000);
        send_cmd(CMD_READ, '0, '0);
        send_cmd(CMD_READ, 32'h8000_0000, '0);
        send_cmd(CMD_READ, 32'h0000_0007, '0);
        send_cmd(CMD_LIST, '0, '0);
        send_cmd(CMD_DEL, '1, '0);
        send_cmd(CMD_DEL, '1, '0);
        send_cmd(CMD_LIST, '0, '0);
        wait_results_done();
    endtask

    task automatic test_spare_codes();
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_cmd(3'(c), $urandom, $urandom);
        wait_results_done();
    endtask

    task automatic test_full_table();
        int                  pick;
        logic [KEY_BITS-1:0] k;
        while (shadow_count < CAPACITY)
            send_cmd(CMD_PUT, $urandom, $urandom);
        send_cmd(CMD_PUT, fresh_key(), $urandom);
        send_cmd(CMD_GET, fresh_key(), $urandom);
        pick = $urandom_range(0, CAPACITY - 1);
        k = shadow_keys[pick];
        send_cmd(CMD_PUT, k, $urandom);
        send_cmd(CMD_GET, k, '0);
        send_cmd(CMD_LIST, '0, '0);
        // drain the table one random key at a time
        while (shadow_count > 0)
            send_cmd(CMD_DEL, shadow_keys[$urandom_range(0, shadow_count - 1)], $urandom);
        send_cmd(CMD_LIST, '0, '0);
        wait_results_done();
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        run_random_cmds(40, 55);
        wait_results_done();
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_cmds(50, 60);
        wait_results_done();
        run_random_cmds(30, 25);
        wait_results_done();
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        run_random_cmds(40, 50);
        wait_results_done();
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_basic_ops();
        test_spare_codes();
        test_full_table();
        test_back_to_back();
        test_random_traffic();
        test_output_hold();

        $display("Ran %0d commands including %0d lists and %0d refusals on a full table;",
                 cmds_sent, list_cmds, full_refusals);
        $display("%0d result words matched against the shadow table.", words_checked);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d result words outstanding", expected_words.size());
        $display("FAIL");
        $finish;
    end

endmodule
